// ===== hw/rtl/lppp_pkg.sv =====
// ----------------------------------------------------------------------------
// Panorama projection package
// Shared widths and the arctangent table of the vectoring CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

package lppp_pkg;

  localparam int CW       = 32;   // CORDIC vector width
  localparam int AW       = 26;   // angle width, signed Q16 degrees
  localparam int STEPS    = 16;   // CORDIC iterations
  localparam int NW       = 56;   // square root radicand width
  localparam int RW       = 28;   // square root result width
  localparam int SQ_STEPS = RW;   // one result bit per stage

  localparam logic signed [AW-1:0] DEG180 = AW'(11796480);

  function automatic logic signed [AW-1:0] atan_q16(input int unsigned i);
    logic signed [AW-1:0] v;
    case (i)
      0:       v = AW'(2949120);
      1:       v = AW'(1740967);
      2:       v = AW'(919879);
      3:       v = AW'(466945);
      4:       v = AW'(234379);
      5:       v = AW'(117304);
      6:       v = AW'(58666);
      7:       v = AW'(29335);
      8:       v = AW'(14668);
      9:       v = AW'(7334);
      10:      v = AW'(3667);
      11:      v = AW'(1833);
      12:      v = AW'(917);
      13:      v = AW'(458);
      14:      v = AW'(229);
      15:      v = AW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lppp_div.sv =====
// ----------------------------------------------------------------------------
// Gray value divider
// Nine-stage restoring divider: a saturation check, then one quotient bit
// per stage, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module lppp_div import lppp_pkg::*; #(
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic          pos,
  input  wire logic [23:0]   num_abs,
  input  wire logic [7:0]    den_abs,
  input  wire logic [PW-1:0] pay_in,
  output logic               out_valid,
  output logic [7:0]         gray,
  output logic [PW-1:0]      pay_out
);

  logic [8:0]    v;
  logic [23:0]   rem [9];
  logic [7:0]    den [9];
  logic [7:0]    q   [9];
  logic          sat [9];
  logic          ps  [9];
  logic [PW-1:0] pay [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      rem[0] <= num_abs;
      den[0] <= den_abs;
      q[0]   <= '0;
      sat[0] <= num_abs >= {den_abs, 16'b0};
      ps[0]  <= pos;
      pay[0] <= pay_in;
    end
  end

  for (genvar k = 1; k < 9; k++) begin : g_stage
    localparam int B = 8 - k;
    logic [23:0] dsh;
    logic        fit;
    assign dsh = 24'(den[k-1]) << (8 + B);
    assign fit = rem[k-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        rem[k]    <= fit ? rem[k-1] - dsh : rem[k-1];
        den[k]    <= den[k-1];
        q[k]      <= q[k-1] | (8'(fit) << B);
        sat[k]    <= sat[k-1];
        ps[k]     <= ps[k-1];
        pay[k]    <= pay[k-1];
      end
    end
  end

  assign out_valid = v[8];
  assign pay_out   = pay[8];
  assign gray      = !ps[8] ? 8'd0 : (sat[8] ? 8'd255 : q[8]);

endmodule

`default_nettype wire

// ===== hw/rtl/lppp_sqrt.sv =====
// ----------------------------------------------------------------------------
// Ground distance square root
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lppp_sqrt import lppp_pkg::*; #(
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] radicand,
  input  wire logic [PW-1:0] pay_in,
  output logic               out_valid,
  output logic [RW-1:0]      root,
  output logic [PW-1:0]      pay_out
);

  logic [SQ_STEPS-1:0] v;
  logic [NW-1:0]       nrem [SQ_STEPS];
  logic [NW-1:0]       r    [SQ_STEPS];
  logic [PW-1:0]       pay  [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_stage
    localparam logic [NW-1:0] BIT = NW'(1) << (NW - 2 - 2 * i);
    logic [NW-1:0] n_src;
    logic [NW-1:0] r_src;
    logic [PW-1:0] p_src;
    logic          v_src;
    logic [NW-1:0] trial;

    if (i == 0) begin : g_first
      assign n_src = radicand;
      assign r_src = '0;
      assign p_src = pay_in;
      assign v_src = in_valid;
    end else begin : g_next
      assign n_src = nrem[i-1];
      assign r_src = r[i-1];
      assign p_src = pay[i-1];
      assign v_src = v[i-1];
    end

    assign trial = r_src + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_src;
      end
      if (en) begin
        if (n_src >= trial) begin
          nrem[i] <= n_src - trial;
          r[i]    <= (r_src >> 1) + BIT;
        end else begin
          nrem[i] <= n_src;
          r[i]    <= r_src >> 1;
        end
        pay[i] <= p_src;
      end
    end
  end

  assign out_valid = v[SQ_STEPS-1];
  assign root      = r[SQ_STEPS-1][RW-1:0];
  assign pay_out   = pay[SQ_STEPS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/lppp_cordic.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Half-plane fold stage followed by sixteen rotation stages; returns the
// angle of the input vector in signed Q16 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module lppp_cordic import lppp_pkg::*; #(
  parameter int PW = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [CW-1:0] vec_x,
  input  wire logic signed [CW-1:0] vec_y,
  input  wire logic [PW-1:0]        pay_in,
  output logic                      out_valid,
  output logic signed [AW-1:0]      angle,
  output logic [PW-1:0]             pay_out
);

  logic [STEPS:0]       v;
  logic signed [CW-1:0] x    [STEPS+1];
  logic signed [CW-1:0] y    [STEPS+1];
  logic signed [AW-1:0] a    [STEPS+1];
  logic                 zero [STEPS+1];
  logic [PW-1:0]        pay  [STEPS+1];

  // Vectors in the left half plane are folded over before rotation.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      zero[0] <= (vec_x == '0) && (vec_y == '0);
      pay[0]  <= pay_in;
      if (vec_x < 0) begin
        x[0] <= -vec_x;
        y[0] <= -vec_y;
        a[0] <= (vec_y >= 0) ? DEG180 : -DEG180;
      end else begin
        x[0] <= vec_x;
        y[0] <= vec_y;
        a[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATAN = atan_q16(i);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          a[i+1] <= a[i] + ATAN;
        end else begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          a[i+1] <= a[i] - ATAN;
        end
        zero[i+1] <= zero[i];
        pay[i+1]  <= pay[i];
      end
    end
  end

  assign out_valid = v[STEPS];
  assign angle     = zero[STEPS] ? '0 : a[STEPS];
  assign pay_out   = pay[STEPS];

endmodule

`default_nettype wire

// ===== hw/rtl/lidar_point_panorama_projection_top.sv =====
// ----------------------------------------------------------------------------
// Lidar point panorama projection
// Maps one lidar point per request to a panorama pixel and a gray value.
// ----------------------------------------------------------------------------
//  port group   direction  handshake             contents
//  in_*         input      in_valid / in_ready   point_x, point_y, point_z, intensity
//  out_*        output     out_valid / out_ready column, row, gray, in_image
//  APB          slave      psel / penable        eight configuration registers
//
// One request is taken every cycle while the skid register is empty. Two
// operand stages, the 9-stage gray divider, the 28-stage square root, the
// 17-stage CORDIC, three mapping stages and the output register follow one
// another.
// Reset is synchronous, clears all valid bits and loads the configuration registers with their defaults.
// A stalled output fills a one-entry skid register; in_ready then drops until
// the skid drains, so the whole pipeline holds without losing a request.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_panorama_projection_top import lppp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [19:0] point_x,
  input  wire logic signed [19:0] point_y,
  input  wire logic signed [19:0] point_z,
  input  wire logic [15:0]        intensity,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [11:0]             column,
  output logic [9:0]              row,
  output logic [7:0]              gray,
  output logic                    in_image,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [2:0] REG_COLS   = 3'd0;
  localparam logic [2:0] REG_ROWS   = 3'd1;
  localparam logic [2:0] REG_COLOFS = 3'd2;
  localparam logic [2:0] REG_ROWOFS = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_RMIN   = 3'd6;
  localparam logic [2:0] REG_RMAX   = 3'd7;

  localparam int DPW = 60 + NW;  // divider payload: radicand and point
  localparam int SPW = 68;       // square root payload: point and gray

  // Configuration registers
  logic [15:0] cols_per_degree;
  logic [15:0] rows_per_degree;
  logic [11:0] col_offset;
  logic [10:0] row_offset;
  logic [12:0] image_width;
  logic [10:0] image_height;
  logic [7:0]  range_min;
  logic [7:0]  range_max;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_per_degree <= 16'd11703;
      rows_per_degree <= 16'd10240;
      col_offset      <= 12'd514;
      row_offset      <= 11'd10;
      image_width     <= 13'd1030;
      image_height    <= 11'd80;
      range_min       <= 8'd0;
      range_max       <= 8'd100;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_COLS:   cols_per_degree <= pwdata[15:0];
        REG_ROWS:   rows_per_degree <= pwdata[15:0];
        REG_COLOFS: col_offset      <= pwdata[11:0];
        REG_ROWOFS: row_offset      <= pwdata[10:0];
        REG_WIDTH:  image_width     <= pwdata[12:0];
        REG_HEIGHT: image_height    <= pwdata[10:0];
        REG_RMIN:   range_min       <= pwdata[7:0];
        REG_RMAX:   range_max       <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COLS:   prdata = 32'(cols_per_degree);
      REG_ROWS:   prdata = 32'(rows_per_degree);
      REG_COLOFS: prdata = 32'(col_offset);
      REG_ROWOFS: prdata = 32'(row_offset);
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_RMIN:   prdata = 32'(range_min);
      REG_RMAX:   prdata = 32'(range_max);
      default:    prdata = '0;
    endcase
  end

  // Pipeline advance; the skid register holds the one result that may
  // arrive while the output is stalled.
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign in_ready = en;

  // Stage 1: squares, intensity offset and range span.
  logic               s1_valid;
  logic signed [39:0] s1_xx;
  logic signed [39:0] s1_yy;
  logic signed [25:0] s1_num;
  logic signed [8:0]  s1_dd;
  logic signed [19:0] s1_x;
  logic signed [19:0] s1_y;
  logic signed [19:0] s1_z;
  logic signed [17:0] diff;

  assign diff = $signed({2'b0, intensity}) - $signed({2'b0, range_min, 8'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_xx  <= point_x * point_x;
      s1_yy  <= point_y * point_y;
      s1_num <= (26'(diff) <<< 8) - 26'(diff);
      s1_dd  <= $signed({1'b0, range_max}) - $signed({1'b0, range_min});
      s1_x   <= point_x;
      s1_y   <= point_y;
      s1_z   <= point_z;
    end
  end

  // Stage 2: radicand and divider operands.
  logic          s2_valid;
  logic [NW-1:0] s2_rad;
  logic [23:0]   s2_num_abs;
  logic [7:0]    s2_den_abs;
  logic          s2_pos;
  logic [59:0]   s2_pt;
  logic [39:0]   sumsq;
  logic signed [25:0] num_neg;
  logic signed [8:0]  dd_neg;

  assign sumsq   = {1'b0, s1_xx[38:0]} + {1'b0, s1_yy[38:0]};
  assign num_neg = -s1_num;
  assign dd_neg  = -s1_dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_rad     <= {sumsq, 16'b0};
      s2_num_abs <= s1_num[25] ? num_neg[23:0] : s1_num[23:0];
      s2_den_abs <= s1_dd[8] ? dd_neg[7:0] : s1_dd[7:0];
      // A positive quotient needs a nonzero span of the same sign.
      s2_pos     <= (s1_num > 0 && s1_dd > 0) || (s1_num < 0 && s1_dd < 0);
      s2_pt      <= {s1_x, s1_y, s1_z};
    end
  end

  // Gray divider
  logic           dv_valid;
  logic [7:0]     dv_gray;
  logic [DPW-1:0] dv_pay;

  lppp_div #(.PW(DPW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .pos       (s2_pos),
    .num_abs   (s2_num_abs),
    .den_abs   (s2_den_abs),
    .pay_in    ({s2_rad, s2_pt}),
    .out_valid (dv_valid),
    .gray      (dv_gray),
    .pay_out   (dv_pay)
  );

  // Ground distance
  logic           sq_valid;
  logic [RW-1:0]  sq_root;
  logic [SPW-1:0] sq_pay;

  lppp_sqrt #(.PW(SPW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid),
    .radicand  (dv_pay[DPW-1:60]),
    .pay_in    ({dv_pay[59:0], dv_gray}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .pay_out   (sq_pay)
  );

  logic signed [19:0] sq_x;
  logic signed [19:0] sq_y;
  logic signed [19:0] sq_z;
  assign sq_x = sq_pay[67:48];
  assign sq_y = sq_pay[47:28];
  assign sq_z = sq_pay[27:8];

  // Azimuth and elevation run side by side.
  logic signed [AW-1:0] az;
  logic signed [AW-1:0] el;
  logic                 cr_valid;
  logic [7:0]           cr_gray;

  lppp_cordic #(.PW(1)) u_cordic_az (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .vec_x     ({{4{sq_x[19]}}, sq_x, 8'b0}),
    .vec_y     ({{4{sq_y[19]}}, sq_y, 8'b0}),
    .pay_in    (1'b0),
    .out_valid (),
    .angle     (az),
    .pay_out   ()
  );

  lppp_cordic #(.PW(8)) u_cordic_el (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .vec_x     ({4'b0, sq_root}),
    .vec_y     ({{4{sq_z[19]}}, sq_z, 8'b0}),
    .pay_in    (sq_pay[7:0]),
    .out_valid (cr_valid),
    .angle     (el),
    .pay_out   (cr_gray)
  );

  // Mapping stage 1: scale the negated angles.
  logic               f1_valid;
  logic signed [43:0] f1_pc;
  logic signed [43:0] f1_pr;
  logic [7:0]         f1_gray;
  logic signed [AW:0] naz;
  logic signed [AW:0] nel;

  assign naz = -(AW+1)'(az);
  assign nel = -(AW+1)'(el);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= cr_valid;
    end
    if (en) begin
      f1_pc   <= naz * $signed({1'b0, cols_per_degree});
      f1_pr   <= nel * $signed({1'b0, rows_per_degree});
      f1_gray <= cr_gray;
    end
  end

  // Mapping stage 2: add the offsets.
  logic               f2_valid;
  logic signed [47:0] f2_sc;
  logic signed [47:0] f2_sr;
  logic [7:0]         f2_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
    if (en) begin
      f2_sc   <= 48'(f1_pc) + $signed({8'b0, col_offset, 28'b0});
      f2_sr   <= 48'(f1_pr) + $signed({{9{row_offset[10]}}, row_offset, 28'b0});
      f2_gray <= f1_gray;
    end
  end

  // Mapping stage 3: truncate toward zero and check the bounds.
  localparam logic signed [47:0] TRUNC_BIAS = 48'((64'd1 << 28) - 64'd1);

  logic               f3_valid;
  logic [11:0]        f3_col;
  logic [9:0]         f3_row;
  logic [7:0]         f3_gray;
  logic               f3_in;
  logic signed [47:0] tc;
  logic signed [47:0] tr;
  logic signed [19:0] col_i;
  logic signed [19:0] row_i;
  logic               in_bounds;

  assign tc    = f2_sc[47] ? f2_sc + TRUNC_BIAS : f2_sc;
  assign tr    = f2_sr[47] ? f2_sr + TRUNC_BIAS : f2_sr;
  assign col_i = tc[47:28];
  assign row_i = tr[47:28];
  assign in_bounds = !col_i[19] && (col_i[18:0] < 19'(image_width))
                  && (col_i[18:0] < 19'd4096)
                  && !row_i[19] && (row_i[18:0] < 19'(image_height))
                  && (row_i[18:0] < 19'd1024);

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (en) begin
      f3_valid <= f2_valid;
    end
    if (en) begin
      f3_col  <= in_bounds ? col_i[11:0] : 12'd0;
      f3_row  <= in_bounds ? row_i[9:0] : 10'd0;
      f3_gray <= f2_gray;
      f3_in   <= in_bounds;
    end
  end

  // Output register and skid register
  logic        out_take;
  logic [11:0] skid_col;
  logic [9:0]  skid_row;
  logic [7:0]  skid_gray;
  logic        skid_in;

  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (f3_valid) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        column   <= skid_col;
        row      <= skid_row;
        gray     <= skid_gray;
        in_image <= skid_in;
      end
    end else if (f3_valid) begin
      if (!out_valid || out_take) begin
        column   <= f3_col;
        row      <= f3_row;
        gray     <= f3_gray;
        in_image <= f3_in;
      end else begin
        skid_col  <= f3_col;
        skid_row  <= f3_row;
        skid_gray <= f3_gray;
        skid_in   <= f3_in;
      end
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register holds a result while the output is empty");

  assert property (@(posedge clk) disable iff (rst)
      $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid register filled while the output was free");

  assert property (@(posedge clk) disable iff (rst) (skid_valid && !out_ready) |=> skid_valid)
    else $error("skid register drained without an output transfer");

  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !in_image) |-> (column == 12'd0 && row == 10'd0))
    else $error("pixel outside the image carries a nonzero position");

  assert property (@(posedge clk) disable iff (rst)
      (out_valid && in_image) |-> (13'(column) < image_width && 11'(row) < image_height))
    else $error("pixel flagged inside the image lies out of bounds");
`endif

endmodule

`default_nettype wire
